### sv/vrr_pkg.sv
// shared constants for the vector range rescale block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
package vrr_pkg;
    localparam int COORD_W_DEF = 24;  // default coordinate width
    localparam int RANGE_W     = 24;  // measured range width
    localparam int OUT_W       = 25;  // scaled coordinate width
    localparam int LANES       = 3;   // x, y and h
endpackage

### sv/vrr_sqrt_cell.sv
// one step of the bit-pair integer square root, registered
// depends on vrr_pkg; chained by vector_range_rescale
`timescale 1ns / 1ps
module vrr_sqrt_cell #(
    parameter int COORD_W = vrr_pkg::COORD_W_DEF,
    parameter int DATA_W  = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [2*COORD_W+1:0]   i_rad,
    input  logic [COORD_W+3:0]     i_rem,
    input  logic [COORD_W:0]       i_root,
    input  logic [DATA_W-1:0]      i_data,
    output logic                   o_valid,
    output logic [2*COORD_W+1:0]   o_rad,
    output logic [COORD_W+3:0]     o_rem,
    output logic [COORD_W:0]       o_root,
    output logic [DATA_W-1:0]      o_data
);
    localparam int NW = 2 * COORD_W + 2;
    localparam int RW = COORD_W + 4;

    logic          r_valid;
    logic [NW-1:0] r_rad;
    logic [RW-1:0] r_rem;
    logic [COORD_W:0] r_root;
    logic [DATA_W-1:0] r_data;

    logic [RW-1:0] n_rem;
    logic [COORD_W:0] n_root;
    logic [NW-1:0] n_rad;
    logic [RW-1:0] shifted;
    logic [RW-1:0] trial;

    // bring in the next bit pair and try the trial subtrahend
    always_comb begin
        shifted = {i_rem[RW-3:0], i_rad[NW-1:NW-2]};
        trial   = {1'b0, i_root, 2'b01};
        n_rad   = {i_rad[NW-3:0], 2'b00};
        if (shifted >= trial) begin
            n_rem  = shifted - trial;
            n_root = {i_root[COORD_W-1:0], 1'b1};
        end else begin
            n_rem  = shifted;
            n_root = {i_root[COORD_W-1:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_data  = r_data;
endmodule

### sv/vrr_div_cell.sv
// one restoring division step for the three coordinate lanes, registered
// depends on vrr_pkg; chained by vector_range_rescale
`timescale 1ns / 1ps
module vrr_div_cell #(
    parameter int COORD_W = vrr_pkg::COORD_W_DEF,
    parameter int DATA_W  = 2
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_valid,
    input  logic [COORD_W:0]                              i_len,
    input  logic [vrr_pkg::LANES-1:0][COORD_W:0]          i_rem,
    input  logic [vrr_pkg::LANES-1:0][vrr_pkg::RANGE_W-1:0] i_low,
    input  logic [DATA_W-1:0]                             i_data,
    output logic                                          o_valid,
    output logic [COORD_W:0]                              o_len,
    output logic [vrr_pkg::LANES-1:0][COORD_W:0]          o_rem,
    output logic [vrr_pkg::LANES-1:0][vrr_pkg::RANGE_W-1:0] o_low,
    output logic [DATA_W-1:0]                             o_data
);
    localparam int RGW = vrr_pkg::RANGE_W;
    localparam int LN  = vrr_pkg::LANES;

    logic                         r_valid;
    logic [COORD_W:0]             r_len;
    logic [LN-1:0][COORD_W:0]     r_rem;
    logic [LN-1:0][RGW-1:0]       r_low;
    logic [DATA_W-1:0]            r_data;

    logic [LN-1:0][COORD_W:0]     n_rem;
    logic [LN-1:0][RGW-1:0]       n_low;

    // per lane: shift in the next dividend bit, subtract when it fits,
    // quotient bit fills in from the bottom
    for (genvar l = 0; l < LN; l++) begin : g_lane
        logic [COORD_W+1:0] part;
        logic [COORD_W+1:0] diff;
        always_comb begin
            part = {i_rem[l], i_low[l][RGW-1]};
            diff = part - {1'b0, i_len};
            if (part >= {1'b0, i_len}) begin
                n_rem[l] = diff[COORD_W:0];
                n_low[l] = {i_low[l][RGW-2:0], 1'b1};
            end else begin
                n_rem[l] = part[COORD_W:0];
                n_low[l] = {i_low[l][RGW-2:0], 1'b0};
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len  <= i_len;
            r_rem  <= n_rem;
            r_low  <= n_low;
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_len   = r_len;
    assign o_rem   = r_rem;
    assign o_low   = r_low;
    assign o_data  = r_data;
endmodule

### sv/vector_range_rescale.sv
// top level: rescales an aiming vector to a measured range
// depends on vrr_pkg, vrr_sqrt_cell and vrr_div_cell
`timescale 1ns / 1ps
// Takes one request per cycle (x, y, h, range) and returns each coordinate
// times range divided by the floor square root of x*x + y*y + h*h, the sum
// of the three squares, truncated toward zero; a zero vector gives zero
// coordinates and the zero_length flag in m_axis_tuser. Throughput is one
// item per clock; the pipeline is the square-root cell row
// (COORD_WIDTH + 1 cells, one root bit each) followed by the divider cell
// row (24 cells, one quotient bit each), plus magnitude, multiply, sum and
// output stages. The whole pipeline holds while a result waits at the
// output with m_axis_tready low.
module vector_range_rescale #(
    parameter int COORD_WIDTH = vrr_pkg::COORD_W_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // aim_x, aim_y, aim_h, measured_range, zero fill
    input  logic [((3*COORD_WIDTH+vrr_pkg::RANGE_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // scaled_x, scaled_y, scaled_h, zero fill
    output logic [((3*vrr_pkg::OUT_W+7)/8)*8-1:0]  m_axis_tdata,
    // zero_length
    output logic                                   m_axis_tuser
);
    localparam int CW   = COORD_WIDTH;
    localparam int RGW  = vrr_pkg::RANGE_W;
    localparam int OW   = vrr_pkg::OUT_W;
    localparam int LN   = vrr_pkg::LANES;
    localparam int NW   = 2 * CW + 2;
    localparam int RW   = CW + 4;
    localparam int PW   = CW + RGW;
    localparam int NSQ  = CW + 1;
    localparam int NDV  = RGW;
    localparam int SQD  = LN + LN * PW;
    localparam int DVD  = LN + 1;
    localparam int ODW  = ((3 * OW + 7) / 8) * 8;

    logic en;

    // stage a: magnitudes and signs
    logic                 r_a_valid;
    logic [LN-1:0][CW-1:0] r_a_mag;
    logic [LN-1:0]        r_a_neg;
    logic [RGW-1:0]       r_a_range;
    logic [LN-1:0][CW-1:0] n_a_mag;

    // stage b: squares and range products
    logic                  r_b_valid;
    logic [LN-1:0][2*CW-1:0] r_b_sq;
    logic [LN-1:0][PW-1:0] r_b_prod;
    logic [LN-1:0]         r_b_neg;

    // stage c: sum of squares
    logic                  r_c_valid;
    logic [NW-1:0]         r_c_sum;
    logic [LN-1:0][PW-1:0] r_c_prod;
    logic [LN-1:0]         r_c_neg;

    // output register
    logic                  r_out_valid;
    logic [LN-1:0][OW-1:0] r_out_val;
    logic                  r_out_zero;
    logic [LN-1:0][OW-1:0] n_out_val;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        for (int l = 0; l < LN; l++) begin
            if (s_axis_tdata[l*CW+CW-1]) begin
                n_a_mag[l] = CW'(~s_axis_tdata[l*CW +: CW] + 1'b1);
            end else begin
                n_a_mag[l] = s_axis_tdata[l*CW +: CW];
            end
        end
    end

    // front stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= s_axis_tvalid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // front stage payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_mag   <= n_a_mag;
            for (int l = 0; l < LN; l++) begin
                r_a_neg[l]  <= s_axis_tdata[l*CW+CW-1];
                r_b_sq[l]   <= r_a_mag[l] * r_a_mag[l];
                r_b_prod[l] <= PW'(r_a_mag[l]) * PW'(r_a_range);
            end
            r_a_range <= s_axis_tdata[LN*CW +: RGW];
            r_b_neg   <= r_a_neg;
            r_c_sum   <= NW'(r_b_sq[0]) + NW'(r_b_sq[1]) + NW'(r_b_sq[2]);
            r_c_prod  <= r_b_prod;
            r_c_neg   <= r_b_neg;
        end
    end

    // square-root cell row
    logic [NSQ:0]               sq_valid;
    logic [NSQ:0][NW-1:0]       sq_rad;
    logic [NSQ:0][RW-1:0]       sq_rem;
    logic [NSQ:0][CW:0]         sq_root;
    logic [NSQ:0][SQD-1:0]      sq_data;

    assign sq_valid[0] = r_c_valid;
    assign sq_rad[0]   = r_c_sum;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_data[0]  = {r_c_neg, r_c_prod};

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        vrr_sqrt_cell #(.COORD_W(CW), .DATA_W(SQD)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_valid[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_data  (sq_data[k]),
            .o_valid (sq_valid[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_data  (sq_data[k+1])
        );
    end

    // divider cell row
    logic [LN-1:0][PW-1:0]        sq_prod;
    logic [LN-1:0]                sq_neg;
    logic [NDV:0]                 dv_valid;
    logic [NDV:0][CW:0]           dv_len;
    logic [NDV:0][LN-1:0][CW:0]   dv_rem;
    logic [NDV:0][LN-1:0][RGW-1:0] dv_low;
    logic [NDV:0][DVD-1:0]        dv_data;

    assign sq_prod = sq_data[NSQ][LN*PW-1:0];
    assign sq_neg  = sq_data[NSQ][SQD-1:LN*PW];

    assign dv_valid[0] = sq_valid[NSQ];
    assign dv_len[0]   = sq_root[NSQ];
    assign dv_data[0]  = {sq_neg, (sq_root[NSQ] == '0)};
    always_comb begin
        for (int l = 0; l < LN; l++) begin
            dv_rem[0][l] = {1'b0, sq_prod[l][PW-1:RGW]};
            dv_low[0][l] = sq_prod[l][RGW-1:0];
        end
    end

    for (genvar k = 0; k < NDV; k++) begin : g_div
        vrr_div_cell #(.COORD_W(CW), .DATA_W(DVD)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_valid[k]),
            .i_len   (dv_len[k]),
            .i_rem   (dv_rem[k]),
            .i_low   (dv_low[k]),
            .i_data  (dv_data[k]),
            .o_valid (dv_valid[k+1]),
            .o_len   (dv_len[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_low   (dv_low[k+1]),
            .o_data  (dv_data[k+1])
        );
    end

    // sign restore and zero-vector masking
    always_comb begin
        for (int l = 0; l < LN; l++) begin
            if (dv_data[NDV][0]) begin
                n_out_val[l] = '0;
            end else if (dv_data[NDV][l+1]) begin
                n_out_val[l] = OW'(~{1'b0, dv_low[NDV][l]} + 1'b1);
            end else begin
                n_out_val[l] = {1'b0, dv_low[NDV][l]};
            end
        end
    end

    // output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid[NDV];
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_val  <= n_out_val;
            r_out_zero <= dv_data[NDV][0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = ODW'(r_out_val);
    assign m_axis_tuser  = r_out_zero;
endmodule

### tb/tb_top.sv
// testbench for vector_range_rescale: random and directed aim vectors and ranges
// depends on vrr_pkg and the vector_range_rescale rtl
`timescale 1ns / 1ps
module tb_top;
    localparam int CW      = vrr_pkg::COORD_W_DEF;
    localparam int RANGE_W = vrr_pkg::RANGE_W;
    localparam int OUT_W   = vrr_pkg::OUT_W;
    localparam int IN_W   = ((3*CW+RANGE_W+7)/8)*8;
    localparam int RES_W  = ((3*OUT_W+7)/8)*8;
    localparam int LATENCY = CW + 29;

    typedef struct packed {
        logic [OUT_W-1:0] sx;
        logic [OUT_W-1:0] sy;
        logic [OUT_W-1:0] sh;
        logic             zero_len;
    } t_rescaled;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [RES_W-1:0] m_axis_tdata;
    logic             m_axis_tuser;

    logic [IN_W-1:0] aim_queue[$];
    t_rescaled       rescaled_queue[$];
    int              errors = 0;
    int              results_seen = 0;
    int              zero_seen = 0;
    bit              stim_done = 0;
    int              send_gap = 0;
    int              recv_gap = 0;

    vector_range_rescale #(.COORD_WIDTH(CW)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // exact floor square root of a 66-bit sum of squares
    function automatic logic [33:0] floor_sqrt(input logic [65:0] v);
        logic [33:0] root;
        logic [67:0] rem;
        logic [67:0] trial;
        root = 0;
        rem = 0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | v[2*i +: 2];
            trial = {root, 2'b01};
            root = root << 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root[0] = 1'b1;
            end
        end
        return root;
    endfunction

    // expected rescaled vector for one request
    function automatic t_rescaled rescale_aim(input logic [IN_W-1:0] d);
        logic signed [CW-1:0] c[3];
        logic [CW:0]          mag[3];
        logic [RANGE_W-1:0]   rng;
        logic [65:0]          sumsq;
        logic [33:0]          len;
        logic [OUT_W-1:0]     q[3];
        logic [63:0]          quo;
        t_rescaled            r;
        rng = d[3*CW +: RANGE_W];
        sumsq = 0;
        for (int k = 0; k < 3; k++) begin
            c[k] = d[k*CW +: CW];
            mag[k] = c[k][CW-1] ? (CW+1)'(-$signed({c[k][CW-1], c[k]})) : {1'b0, c[k]};
            sumsq = sumsq + 66'(mag[k]) * 66'(mag[k]);
        end
        len = floor_sqrt(sumsq);
        for (int k = 0; k < 3; k++) begin
            quo = (len == 0) ? 64'd0 : (64'(mag[k]) * 64'(rng)) / 64'(len);
            q[k] = c[k][CW-1] ? OUT_W'(-quo) : OUT_W'(quo);
        end
        r.sx = q[0];
        r.sy = q[1];
        r.sh = q[2];
        r.zero_len = (len == 0);
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_aim(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                                 input logic [CW-1:0] h,
                                                 input logic [RANGE_W-1:0] rng);
        logic [IN_W-1:0] d;
        d = '0;
        d[0 +: CW] = x;
        d[CW +: CW] = y;
        d[2*CW +: CW] = h;
        d[3*CW +: RANGE_W] = rng;
        return d;
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return CW'($urandom_range(0, 255)) - CW'(128);
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return {1'b0, {(CW-1){1'b1}}};
            3: return CW'($urandom_range(0, 4095));
            default: return CW'($urandom);
        endcase
    endfunction

    // stimulus: directed corners then random vectors
    initial begin
        logic [CW-1:0] cmin;
        logic [CW-1:0] cmax;
        logic [RANGE_W-1:0] rmax;
        cmin = {1'b1, {(CW-1){1'b0}}};
        cmax = {1'b0, {(CW-1){1'b1}}};
        rmax = '1;
        aim_queue.push_back(pack_aim('0, '0, '0, rmax));
        aim_queue.push_back(pack_aim('0, '0, '0, '0));
        aim_queue.push_back(pack_aim(cmin, cmin, cmin, rmax));
        aim_queue.push_back(pack_aim(cmax, cmax, cmax, rmax));
        aim_queue.push_back(pack_aim(cmin, '0, '0, rmax));
        aim_queue.push_back(pack_aim('0, cmax, '0, rmax));
        aim_queue.push_back(pack_aim('0, '0, cmin, rmax));
        aim_queue.push_back(pack_aim(CW'(1), '0, '0, rmax));
        aim_queue.push_back(pack_aim('1, '1, '1, rmax));
        aim_queue.push_back(pack_aim(cmax, cmin, CW'(1), RANGE_W'(12345)));
        aim_queue.push_back(pack_aim(CW'(3), CW'(4), '0, '0));
        aim_queue.push_back(pack_aim(cmin, cmax, '0, RANGE_W'(1)));
        aim_queue.push_back(pack_aim(-CW'(3), CW'(4), -CW'(12), RANGE_W'(256)));
        aim_queue.push_back(pack_aim(CW'(1), CW'(1), CW'(1), rmax));
        for (int n = 0; n < 1700; n++) begin
            logic [RANGE_W-1:0] rng;
            case ($urandom_range(0, 9))
                0: rng = '0;
                1: rng = rmax;
                default: rng = RANGE_W'($urandom);
            endcase
            if ($urandom_range(0, 39) == 0)
                aim_queue.push_back(pack_aim('0, '0, '0, rng));
            else
                aim_queue.push_back(pack_aim(rand_coord(), rand_coord(), rand_coord(), rng));
        end
        stim_done = 1;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            send_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid)
                rescaled_queue.push_back(rescale_aim(s_axis_tdata));
            if (send_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (aim_queue.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= aim_queue.pop_front();
                send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_rescaled want;
                t_rescaled got;
                got.sx = m_axis_tdata[0 +: OUT_W];
                got.sy = m_axis_tdata[OUT_W +: OUT_W];
                got.sh = m_axis_tdata[2*OUT_W +: OUT_W];
                got.zero_len = m_axis_tuser;
                results_seen <= results_seen + 1;
                if (rescaled_queue.size() == 0) begin
                    $error("unexpected result %h", m_axis_tdata);
                    errors++;
                end else begin
                    want = rescaled_queue.pop_front();
                    if (got.zero_len) zero_seen <= zero_seen + 1;
                    if (got.sx !== want.sx) begin
                        $error("scaled_x expected %h actual %h", want.sx, got.sx);
                        errors++;
                    end
                    if (got.sy !== want.sy) begin
                        $error("scaled_y expected %h actual %h", want.sy, got.sy);
                        errors++;
                    end
                    if (got.sh !== want.sh) begin
                        $error("scaled_h expected %h actual %h", want.sh, got.sh);
                        errors++;
                    end
                    if (got.zero_len !== want.zero_len) begin
                        $error("zero_length expected %b actual %b", want.zero_len, got.zero_len);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                m_axis_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_axis_tready <= 1'b1;
                recv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            end
        end
    end

    // reset, then wait for drain
    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && aim_queue.size() == 0);
        @(posedge i_clk);
        while (s_axis_tvalid || rescaled_queue.size() > 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        $display("covered %0d results, %0d zero-length vectors, corner coordinates and ranges",
                 results_seen, zero_seen);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // timeout
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

### sim.f
sv/vrr_pkg.sv
sv/vrr_sqrt_cell.sv
sv/vrr_div_cell.sv
sv/vector_range_rescale.sv
tb/tb_top.sv
